// ----- rtl/bole_pkg.sv -----
// shared constants, codes and types for the bounded ordered list engine
package bole_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int ST_W     = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_START       = 3'd0,
    ACT_APPEND      = 3'd1,
    ACT_INSERT      = 3'd2,
    ACT_REMOVE_TAIL = 3'd3,
    ACT_REMOVE_VAL  = 3'd4,
    ACT_FIND        = 3'd5,
    ACT_CLEAR       = 3'd6
  } act_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// ----- rtl/bole_cell.sv -----
// one list slot: holds an entry, compares it and shifts with its neighbors
module bole_cell (
  input  logic                      clk,
  input  bole_pkg::cell_ctl_t       ctl,
  input  logic [bole_pkg::DATA_W-1:0] wr_val,
  input  logic                      cmp_en,
  input  logic [bole_pkg::DATA_W-1:0] cmp_val,
  input  logic [bole_pkg::DATA_W-1:0] left_data,
  input  logic [bole_pkg::DATA_W-1:0] right_data,
  output logic [bole_pkg::DATA_W-1:0] data,
  output logic                      match
);
  import bole_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= wr_val;
    end else if (ctl.take_left) begin
      data <= left_data;
    end else if (ctl.take_right) begin
      data <= right_data;
    end
    if (cmp_en) begin
      match <= (data == cmp_val);
    end
  end

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// top level: request control, first-match search and the row of list cells
// a request is compared on accept, then passes the search state and the update state
// a new request is taken only once the previous update has committed
// a result waits in an output register while the next request is taken
// reset: synchronous active-high rst empties the list and drops any pending result
// entry storage is not cleared; only entries below the count are ever read
module bounded_ordered_list_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bole_pkg::ACT_W-1:0]   action,
  input  logic signed [bole_pkg::DATA_W-1:0] value,
  input  logic [bole_pkg::CNT_W-1:0]   position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bole_pkg::ST_W-1:0]    status,
  output logic [bole_pkg::CNT_W-1:0]   match_position,
  output logic [bole_pkg::CNT_W-1:0]   entry_count,
  output logic [bole_pkg::CNT_W-1:0]   free_slots
);
  import bole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [ACT_W-1:0]    req_act;
  logic [DATA_W-1:0]   req_val;
  logic [CNT_W-1:0]    req_pos;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [IDX_W-1:0]    hit_idx;
  logic                found;
  logic                accept;
  logic                commit;

  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  cell_ctl_t           cell_ctl  [CAPACITY];

  logic [CAPACITY-1:0] live_match;
  logic [CAPACITY-1:0] first_hot;
  logic [IDX_W-1:0]    first_idx;

  status_t             st;
  logic [CNT_W-1:0]    mpos;
  logic                do_load;
  logic                do_ins;
  logic                do_rem;
  logic [IDX_W-1:0]    op_idx;
  logic [CNT_W-1:0]    ins_k;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_act <= action;
      req_val <= value;
      req_pos <= position;
    end
  end

  // first match among live entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live_match[i] = cell_match[i] && (CNT_W'(i) < count);
    end
    first_hot = live_match & (~live_match + CAPACITY'(1));
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hot[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SRCH) begin
      hit_idx <= first_idx;
      found   <= |live_match;
    end
  end

  // request decode
  always_comb begin
    st         = ST_OK;
    mpos       = '0;
    count_next = count;
    do_load    = 1'b0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    op_idx     = '0;
    ins_k      = req_pos - CNT_W'(1);
    case (act_t'(req_act))
      ACT_START: begin
        do_load    = 1'b1;
        count_next = CNT_W'(1);
      end
      ACT_APPEND: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (count >= CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          do_load    = 1'b1;
          op_idx     = count[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      ACT_INSERT: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (count >= CNT_W'(CAPACITY)) begin
          st = ST_FULL;
        end else if (req_pos == '0
                     || {1'b0, req_pos} > ({1'b0, count} + (CNT_W+1)'(1))) begin
          st = ST_BADPOS;
        end else begin
          do_load    = 1'b1;
          do_ins     = 1'b1;
          op_idx     = ins_k[IDX_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      ACT_REMOVE_TAIL: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      ACT_REMOVE_VAL: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (!found) begin
          st = ST_NOTFOUND;
        end else begin
          do_rem     = 1'b1;
          op_idx     = hit_idx;
          mpos       = CNT_W'(hit_idx) + CNT_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      ACT_FIND: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (!found) begin
          st = ST_NOTFOUND;
        end else begin
          mpos = CNT_W'(hit_idx) + CNT_W'(1);
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_body
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    assign cell_ctl[g].load       = commit && do_load && (IDX_W'(g) == op_idx);
    assign cell_ctl[g].take_left  = commit && do_ins && (IDX_W'(g) > op_idx);
    assign cell_ctl[g].take_right = commit && do_rem && (IDX_W'(g) >= op_idx);

    bole_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .wr_val     (req_val),
      .cmp_en     (accept),
      .cmp_val    (value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= st;
      match_position <= mpos;
      entry_count    <= count_next;
      free_slots     <= CNT_W'(CAPACITY) - count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result raised without an update step");

  a_slots_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count + free_slots == CNT_W'(CAPACITY)))
    else $error("count and free slots disagree");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> !(accept && $past(state == S_SRCH)))
    else $error("request taken while busy");
`endif

endmodule

// ----- verif/bole_checker.sv -----
// request/result scoreboard for the bounded ordered list engine: predicts and compares
`timescale 1ns / 100ps

module bole_checker
  import bole_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [DATA_W-1:0] value,
  input  logic [CNT_W-1:0]         position,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ST_W-1:0]          status,
  input  logic [CNT_W-1:0]         match_position,
  input  logic [CNT_W-1:0]         entry_count,
  input  logic [CNT_W-1:0]         free_slots,
  output int                       fail_count,
  output int                       pending_results
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] match_pos;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] free;
  } list_result_t;

  logic [DATA_W-1:0] list_words [CAPACITY];
  int                list_len;
  list_result_t      expected_results [$];

  function automatic int first_match_index(logic [DATA_W-1:0] val);
    for (int i = 0; i < list_len; i++) begin
      if (list_words[i] == val) return i;
    end
    return -1;
  endfunction

  function automatic list_result_t apply_list_request(logic [ACT_W-1:0] act,
                                                      logic [DATA_W-1:0] val,
                                                      logic [CNT_W-1:0] pos);
    list_result_t res;
    int           idx;
    res.status    = ST_OK;
    res.match_pos = '0;
    case (act) inside
      ACT_START: begin
        list_words[0] = val;
        list_len = 1;
      end
      ACT_APPEND: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (list_len >= CAPACITY) res.status = ST_FULL;
        else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      ACT_INSERT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (list_len >= CAPACITY) res.status = ST_FULL;
        else if (pos == 0 || int'(pos) > list_len + 1) res.status = ST_BADPOS;
        else begin
          for (int i = list_len; i > int'(pos) - 1; i--) list_words[i] = list_words[i-1];
          list_words[int'(pos) - 1] = val;
          list_len++;
        end
      end
      ACT_REMOVE_TAIL: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      ACT_REMOVE_VAL, ACT_FIND: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else begin
          idx = first_match_index(val);
          if (idx < 0) res.status = ST_NOTFOUND;
          else begin
            res.match_pos = CNT_W'(idx + 1);
            if (act == ACT_REMOVE_VAL) begin
              for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
              list_len--;
            end
          end
        end
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = CNT_W'(list_len);
    res.free  = CNT_W'(CAPACITY - list_len);
    return res;
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
    end
  endfunction

  initial begin
    fail_count      = 0;
    pending_results = 0;
    list_len        = 0;
  end

  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(apply_list_request(action, value, position));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result with no request waiting");
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", exp_res.status, status);
          check_field("match_position", exp_res.match_pos, match_position);
          check_field("entry_count", exp_res.count, entry_count);
          check_field("free_slots", exp_res.free, free_slots);
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// testbench top for the bounded ordered list engine: clock, reset, request stimulus, verdict
`timescale 1ns / 100ps

module tb_top;
  import bole_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 850;
  localparam int PHASE_LEN       = 70;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;
  logic [CNT_W-1:0]         position;
  logic                     out_valid;
  logic                     out_ready;
  logic [ST_W-1:0]          status;
  logic [CNT_W-1:0]         match_position;
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         free_slots;
  int                       fail_count;
  int                       pending_results;
  bit                       no_idle;
  logic [DATA_W-1:0]        recent_values [16];
  int                       recent_wr;

  bounded_ordered_list_engine uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .match_position (match_position),
    .entry_count    (entry_count),
    .free_slots     (free_slots)
  );

  bole_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .value           (value),
    .position        (position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .match_position  (match_position),
    .entry_count     (entry_count),
    .free_slots      (free_slots),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                              input logic [CNT_W-1:0] pos);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action   <= act;
    value    <= val;
    position <= pos;
    in_valid <= 1'b1;
    if (act == ACT_START || act == ACT_APPEND || act == ACT_INSERT) begin
      recent_values[recent_wr] = val;
      recent_wr = (recent_wr + 1) % 16;
    end
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [ACT_W-1:0] pick_action(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) begin
      if (r < 45) return ACT_APPEND;
      if (r < 70) return ACT_INSERT;
      if (r < 80) return ACT_FIND;
      if (r < 88) return ACT_REMOVE_VAL;
      if (r < 93) return ACT_REMOVE_TAIL;
      if (r < 96) return ACT_START;
      if (r < 98) return ACT_UNUSED;
      return ACT_CLEAR;
    end
    if (mode == 1) begin
      if (r < 30) return ACT_REMOVE_TAIL;
      if (r < 60) return ACT_REMOVE_VAL;
      if (r < 78) return ACT_FIND;
      if (r < 88) return ACT_APPEND;
      if (r < 93) return ACT_INSERT;
      if (r < 96) return ACT_CLEAR;
      if (r < 98) return ACT_UNUSED;
      return ACT_START;
    end
    return ACT_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return recent_values[$urandom_range(0, 15)];
    if (r < 7) return DATA_W'($urandom_range(0, 15) - 8);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [CNT_W-1:0] pick_position(logic [ACT_W-1:0] act);
    int r;
    r = $urandom_range(0, 99);
    if (act == ACT_INSERT && r < 80) return CNT_W'($urandom_range(1, CAPACITY + 1));
    if (act == ACT_INSERT && r < 90) return '0;
    return CNT_W'($urandom_range(0, 63));
  endfunction

  initial begin
    logic [ACT_W-1:0] act;
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = '0;
    value     = '0;
    position  = '0;
    no_idle   = 1'b0;
    recent_wr = 0;
    for (int i = 0; i < 16; i++) recent_values[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty list cases
    send_request(ACT_REMOVE_TAIL, 32'd0, 6'd0);
    send_request(ACT_APPEND, 32'd1, 6'd0);
    send_request(ACT_INSERT, 32'd2, 6'd1);
    send_request(ACT_REMOVE_VAL, 32'd3, 6'd0);
    send_request(ACT_FIND, 32'd4, 6'd0);
    send_request(ACT_CLEAR, 32'd0, 6'd0);
    send_request(ACT_UNUSED, 32'd5, 6'd63);
    // start, restart on non-empty list, value extremes
    send_request(ACT_START, 32'h8000_0000, 6'd0);
    send_request(ACT_START, 32'h7fff_ffff, 6'd0);
    send_request(ACT_APPEND, 32'h0000_0000, 6'd0);
    send_request(ACT_APPEND, 32'hffff_ffff, 6'd0);
    send_request(ACT_INSERT, 32'd5, 6'd1);
    // insert position edges
    send_request(ACT_INSERT, 32'd6, 6'd0);
    send_request(ACT_INSERT, 32'd7, 6'd63);
    send_request(ACT_INSERT, 32'd8, 6'd6);
    send_request(ACT_INSERT, 32'd9, 6'd5);
    send_request(ACT_FIND, 32'h7fff_ffff, 6'd0);
    send_request(ACT_FIND, 32'd12345, 6'd0);
    send_request(ACT_REMOVE_VAL, 32'hffff_ffff, 6'd0);
    send_request(ACT_REMOVE_VAL, 32'd999, 6'd0);
    send_request(ACT_REMOVE_TAIL, 32'd0, 6'd0);
    send_request(ACT_UNUSED, 32'hffff_ffff, 6'd42);
    send_request(ACT_CLEAR, 32'd0, 6'd0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % PHASE_LEN == 0) begin
        no_idle = ((i / PHASE_LEN) % 4 == 3);
        send_request(ACT_START, pick_value(), pick_position(ACT_START));
      end else begin
        act = pick_action((i / PHASE_LEN) % 3);
        send_request(act, pick_value(), pick_position(act));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

endmodule

// ----- files.f -----
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
verif/bole_checker.sv
verif/tb_top.sv
